### rtl/whfc_pkg.sv
`default_nettype none

package whfc_pkg;

	localparam logic [1:0] SEL_FAULT = 2'd0;
	localparam logic [1:0] SEL_SHORT = 2'd1;
	localparam logic [1:0] SEL_OPEN  = 2'd2;

	localparam int unsigned QUEUE_DEPTH = 4;
	localparam int unsigned QPTR_W      = 2;
	localparam int unsigned QCNT_W      = 3;

	localparam logic [11:0] SUM_MAX = 12'hFFF;
	localparam logic [8:0]  IDX_MAX = 9'h1FF;

	typedef struct packed {
		logic [7:0]  fault_mask;
		logic [7:0]  short_mask;
		logic [7:0]  open_mask;
		logic [7:0]  sel_mask;
		logic [8:0]  base;
		logic [11:0] fault_total;
		logic [11:0] short_total;
		logic [11:0] open_total;
		logic        vector_done;
		logic        overflow;
	} entry_t;

	function automatic logic [3:0] popcount8(input logic [7:0] v);
		logic [3:0] c;
		c = 4'd0;
		for (int b = 0; b < 8; b++) begin
			c = c + {3'd0, v[b]};
		end
		return c;
	endfunction

	function automatic logic [11:0] sat_add(input logic [11:0] a, input logic [3:0] b);
		logic [12:0] s;
		s = {1'b0, a} + {9'd0, b};
		return s[12] ? SUM_MAX : s[11:0];
	endfunction

endpackage

`default_nettype wire

### rtl/wire_harness_fault_classifier_unit.sv
// Wire harness fault classifier. Each input word carries one byte of expected
// and one byte of measured wire states on s_tdata, with s_tlast marking the
// final byte of a test vector. The front stage forms the fault, short and open
// masks, updates the saturating running totals and the byte index, and writes
// one entry into a four-deep queue. The back stage turns each entry into one
// output word per wire listed from the mask chosen by list_select, lowest wire
// number first, or into a single word with wire_valid low when nothing is
// listed. m_tlast marks the final word produced by one input byte.
// m_tvalid rises once an accepted byte has been written into the queue and
// then loaded into the back stage's current-entry register. The input
// side takes one byte per cycle while the queue has room; the back stage
// emits one word per cycle while m_tready is high, so a byte with n listed
// wires yields n words, sustained input is one byte per cycle when bytes produce
// a single word. When the receiver holds m_tready low, the current word stays
// stable, the queue fills, and s_tready falls once it is full.
// Reset clears the totals, the byte index, the queue and list_select. The user
// writes list_select over the APB port at address 0 only while idle; not enforced.
`default_nettype none

module wire_harness_fault_classifier_unit #(
	parameter int unsigned MAX_WIRES = 256
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [15:0] s_tdata,  // expected_byte, measured_byte
	input  wire logic        s_tlast,  // last_byte
	output logic             m_tvalid,
	input  wire logic        m_tready,
	// fault_mask, short_mask, open_mask, wire_number, wire_valid,
	// fault_total, short_total, open_total, zero padding
	output logic [71:0]      m_tdata,
	output logic             m_tlast,  // last_of_item
	output logic [1:0]       m_tuser,  // vector_done, overflow
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [2:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic [31:0]      prdata,
	output logic             pready
);
	import whfc_pkg::*;

	logic [1:0]  list_select_q;
	logic        full;
	logic        accept;
	logic        head_valid;
	logic        pop;
	entry_t      push_entry;
	entry_t      head_entry;
	entry_t      out_entry;
	logic [8:0]  wire_number;
	logic        wire_valid;
	logic        last_of_item;

	assign pready   = 1'b1;
	assign prdata   = paddr[2] ? 32'd0 : {30'd0, list_select_q};
	assign s_tready = !full;
	assign accept   = s_tvalid && !full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			list_select_q <= SEL_FAULT;
		end else if (psel && penable && pwrite && pready && !paddr[2]) begin
			list_select_q <= pwdata[1:0];
		end
	end

	whfc_front #(
		.MAX_WIRES(MAX_WIRES)
	) u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.accept        (accept),
		.expected_byte (s_tdata[7:0]),
		.measured_byte (s_tdata[15:8]),
		.last_byte     (s_tlast),
		.list_select   (list_select_q),
		.entry         (push_entry)
	);

	whfc_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (accept),
		.push_entry (push_entry),
		.full       (full),
		.pop        (pop),
		.head_valid (head_valid),
		.head_entry (head_entry)
	);

	whfc_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.head_valid   (head_valid),
		.head_entry   (head_entry),
		.pop          (pop),
		.out_valid    (m_tvalid),
		.out_ready    (m_tready),
		.out_entry    (out_entry),
		.wire_number  (wire_number),
		.wire_valid   (wire_valid),
		.last_of_item (last_of_item)
	);

	assign m_tdata = {2'b00, out_entry.open_total, out_entry.short_total,
		out_entry.fault_total, wire_valid, wire_number, out_entry.open_mask,
		out_entry.short_mask, out_entry.fault_mask};
	assign m_tlast = last_of_item;
	assign m_tuser = {out_entry.overflow, out_entry.vector_done};

endmodule

`default_nettype wire

### rtl/whfc_front.sv
`default_nettype none

module whfc_front #(
	parameter int unsigned MAX_WIRES = 256
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              accept,
	input  wire logic [7:0]        expected_byte,
	input  wire logic [7:0]        measured_byte,
	input  wire logic              last_byte,
	input  wire logic [1:0]        list_select,
	output whfc_pkg::entry_t       entry
);
	import whfc_pkg::*;

	localparam int unsigned ByteLimit = MAX_WIRES / 8;

	logic [8:0]  byte_index_q;
	logic [11:0] fault_sum_q;
	logic [11:0] short_sum_q;
	logic [11:0] open_sum_q;

	logic [7:0]  fmask;
	logic [7:0]  smask;
	logic [7:0]  omask;
	logic [7:0]  sel;
	logic        ovf;
	logic [11:0] fault_nx;
	logic [11:0] short_nx;
	logic [11:0] open_nx;

	always_comb begin
		fmask    = expected_byte ^ measured_byte;
		smask    = fmask & expected_byte;
		omask    = fmask & measured_byte;
		fault_nx = sat_add(fault_sum_q, popcount8(fmask));
		short_nx = sat_add(short_sum_q, popcount8(smask));
		open_nx  = sat_add(open_sum_q, popcount8(omask));
		case (list_select)
			SEL_FAULT: sel = fmask;
			SEL_SHORT: sel = smask;
			SEL_OPEN:  sel = omask;
			default:   sel = 8'd0;
		endcase
		ovf = (32'(byte_index_q) >= ByteLimit);
		if (ovf) begin
			sel = 8'd0;
		end
		entry.fault_mask  = fmask;
		entry.short_mask  = smask;
		entry.open_mask   = omask;
		entry.sel_mask    = sel;
		entry.base        = {byte_index_q[5:0], 3'b000} + 9'd8;
		entry.fault_total = fault_nx;
		entry.short_total = short_nx;
		entry.open_total  = open_nx;
		entry.vector_done = last_byte;
		entry.overflow    = ovf;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_index_q <= '0;
			fault_sum_q  <= '0;
			short_sum_q  <= '0;
			open_sum_q   <= '0;
		end else if (accept) begin
			if (last_byte) begin
				byte_index_q <= '0;
				fault_sum_q  <= '0;
				short_sum_q  <= '0;
				open_sum_q   <= '0;
			end else begin
				if (byte_index_q != IDX_MAX) begin
					byte_index_q <= byte_index_q + 9'd1;
				end
				fault_sum_q <= fault_nx;
				short_sum_q <= short_nx;
				open_sum_q  <= open_nx;
			end
		end
	end

endmodule

`default_nettype wire

### rtl/whfc_queue.sv
`default_nettype none

module whfc_queue (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              push,
	input  wire whfc_pkg::entry_t  push_entry,
	output logic                   full,
	input  wire logic              pop,
	output logic                   head_valid,
	output whfc_pkg::entry_t       head_entry
);
	import whfc_pkg::*;

	entry_t              mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0]   wr_ptr_q;
	logic [QPTR_W-1:0]   rd_ptr_q;
	logic [QCNT_W-1:0]   count_q;

	assign full       = (count_q == QCNT_W'(QUEUE_DEPTH));
	assign head_valid = (count_q != '0);
	assign head_entry = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + QCNT_W'(1);
				2'b01:   count_q <= count_q - QCNT_W'(1);
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

`default_nettype wire

### rtl/whfc_back.sv
`default_nettype none

module whfc_back (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              head_valid,
	input  wire whfc_pkg::entry_t  head_entry,
	output logic                   pop,
	output logic                   out_valid,
	input  wire logic              out_ready,
	output whfc_pkg::entry_t       out_entry,
	output logic [8:0]             wire_number,
	output logic                   wire_valid,
	output logic                   last_of_item
);
	import whfc_pkg::*;

	entry_t      cur_q;
	logic [7:0]  rem_q;
	logic        cur_valid_q;

	logic [2:0]  top;
	logic [7:0]  rem_nx;
	logic        taken;

	always_comb begin
		top = 3'd0;
		for (int b = 0; b < 8; b++) begin
			if (rem_q[b]) begin
				top = 3'(b);
			end
		end
		rem_nx       = rem_q & ~(8'd1 << top);
		wire_valid   = (rem_q != 8'd0);
		wire_number  = wire_valid ? (cur_q.base - {6'd0, top}) : 9'd0;
		last_of_item = (rem_nx == 8'd0);
		out_valid    = cur_valid_q;
		out_entry    = cur_q;
		taken        = cur_valid_q && out_ready;
		pop          = head_valid && (!cur_valid_q || (taken && last_of_item));
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			cur_q <= head_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_valid_q <= 1'b0;
			rem_q       <= '0;
		end else if (pop) begin
			cur_valid_q <= 1'b1;
			rem_q       <= head_entry.sel_mask;
		end else if (taken) begin
			if (last_of_item) begin
				cur_valid_q <= 1'b0;
			end
			rem_q <= rem_nx;
		end
	end

endmodule

`default_nettype wire
